[hdl/whc_pkg.sv]
// ----------------------------------------------------------------------------
// whc_pkg
// Shared types, constants and tag lookup for the wav header checker.
// ----------------------------------------------------------------------------
`default_nettype none

package whc_pkg;

    // header geometry
    localparam int unsigned HDR_LEN   = 44;
    localparam int unsigned IDX_W     = 6;
    localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HDR_LEN - 1);

    // size offsets checked against the configured file size
    localparam logic [31:0] RIFF_OFS = 32'd8;
    localparam logic [31:0] DATA_OFS = 32'd44;
    localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
    localparam logic [15:0] FMT_CODE_PCM = 16'd1;

    // result codes
    typedef enum logic [3:0] {
        STAT_OK       = 4'd0,
        STAT_RIFF     = 4'd1,
        STAT_FSIZE    = 4'd2,
        STAT_WAVE     = 4'd3,
        STAT_TAG      = 4'd4,
        STAT_NOTPCM   = 4'd5,
        STAT_FMTSIZE  = 4'd6,
        STAT_BRATE    = 4'd7,
        STAT_ALIGN    = 4'd8,
        STAT_DSIZE    = 4'd9
    } status_t;

    // tag flag bit positions
    localparam int unsigned TAG_RIFF_BIT = 0;
    localparam int unsigned TAG_WAVE_BIT = 1;
    localparam int unsigned TAG_FMT_BIT  = 2;
    localparam int unsigned TAG_DATA_BIT = 3;

    // expected tag characters, byte 0 first
    localparam logic [7:0] RIFF_CHARS [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
    localparam logic [7:0] WAVE_CHARS [4] = '{8'h57, 8'h41, 8'h56, 8'h45};
    localparam logic [7:0] FMT_CHARS  [4] = '{8'h66, 8'h6d, 8'h74, 8'h20};
    localparam logic [7:0] DATA_CHARS [4] = '{8'h64, 8'h61, 8'h74, 8'h61};

    // command from controller to datapath
    typedef struct packed {
        logic             capture;  // process one header beat
        logic             restart;  // beat is header byte 0
        logic [IDX_W-1:0] index;    // position of the beat in the header
        logic             load;     // judge header and fill result register
    } whc_cmd_t;

    typedef struct packed {
        logic [3:0] mask;
        logic [7:0] expect_byte;
    } tag_check_t;

    // which tag a header position belongs to and the byte it should hold
    function automatic tag_check_t tag_lookup(logic [IDX_W-1:0] idx);
        tag_check_t t;
        t.mask        = 4'b0000;
        t.expect_byte = 8'h00;
        case (idx) inside
            [6'd0:6'd3]:
            begin
                t.mask[TAG_RIFF_BIT] = 1'b1;
                t.expect_byte = RIFF_CHARS[idx[1:0]];
            end
            [6'd8:6'd11]:
            begin
                t.mask[TAG_WAVE_BIT] = 1'b1;
                t.expect_byte = WAVE_CHARS[idx[1:0]];
            end
            [6'd12:6'd15]:
            begin
                t.mask[TAG_FMT_BIT] = 1'b1;
                t.expect_byte = FMT_CHARS[idx[1:0]];
            end
            [6'd36:6'd39]:
            begin
                t.mask[TAG_DATA_BIT] = 1'b1;
                t.expect_byte = DATA_CHARS[idx[1:0]];
            end
            default:
            begin
                t.mask = 4'b0000;
            end
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[hdl/whc_ctrl.sv]
// ----------------------------------------------------------------------------
// whc_ctrl
// Header position tracking, result handshake and commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module whc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_valid,
    input  wire logic            s_first,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output whc_pkg::whc_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PARSE,
        ST_JUDGE
    } state_t;

    state_t                     state_reg, state_next;
    logic [whc_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       accept;

    // commands and next state
    always_comb
    begin
        s_ready     = (state_reg != ST_JUDGE);
        accept      = s_valid && s_ready;
        cmd.restart = accept && s_first;
        cmd.capture = accept && (s_first || (state_reg == ST_PARSE));
        cmd.index   = s_first ? '0 : idx_reg;
        cmd.load    = (state_reg == ST_JUDGE) && (!out_valid_reg || m_ready);

        state_next  = state_reg;
        idx_next    = idx_reg;
        if (cmd.capture)
        begin
            if (cmd.index == whc_pkg::HDR_LAST)
            begin
                state_next = ST_JUDGE;
            end
            else
            begin
                state_next = ST_PARSE;
                idx_next   = cmd.index + 1'b1;
            end
        end
        else if (cmd.load)
        begin
            state_next = ST_IDLE;
        end

        if (cmd.load)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

[hdl/whc_datapath.sv]
// ----------------------------------------------------------------------------
// whc_datapath
// Field assembly, tag compare, rate products and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module whc_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire whc_pkg::whc_cmd_t  cmd,
    input  wire logic [7:0]         hdr_byte,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    output logic [3:0]              status,
    output logic [15:0]             channel_count,
    output logic [31:0]             rate_hz,
    output logic [15:0]             sample_bits,
    output logic [31:0]             payload_size
);

    logic [31:0] total_len_reg;
    logic [3:0]  tag_flags_reg, tag_flags_next;
    logic [31:0] riff_size_reg;
    logic [31:0] fmt_size_reg;
    logic [15:0] format_reg;
    logic [15:0] chan_reg;
    logic [31:0] rate_reg;
    logic [31:0] brate_reg;
    logic [15:0] align_reg;
    logic [15:0] bits_reg;
    logic [31:0] dsize_reg;
    logic [31:0] cb_prod_reg;
    logic [31:0] rcb_prod_reg;
    logic [3:0]  status_reg;
    logic [15:0] chan_out_reg;
    logic [31:0] rate_out_reg;
    logic [15:0] bits_out_reg;
    logic [31:0] dsize_out_reg;

    whc_pkg::tag_check_t tchk;
    whc_pkg::status_t    status_next;
    logic [31:0]         exp_brate;
    logic [31:0]         exp_align;
    logic                fsize_bad;
    logic                dsize_bad;

    // configured file size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_len_reg <= whc_pkg::DATA_OFS;
        else if (cfg_we)
            total_len_reg <= cfg_wdata;
    end

    // tag match flags, cleared to all-match on restart
    always_comb
    begin
        tchk           = whc_pkg::tag_lookup(cmd.index);
        tag_flags_next = cmd.restart ? 4'b1111 : tag_flags_reg;
        if (hdr_byte != tchk.expect_byte)
            tag_flags_next = tag_flags_next & ~tchk.mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_flags_reg <= 4'b1111;
        else if (cmd.capture)
            tag_flags_reg <= tag_flags_next;
    end

    // little-endian field assembly, shifting in from the top
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            case (cmd.index) inside
                [6'd4:6'd7]:   riff_size_reg <= {hdr_byte, riff_size_reg[31:8]};
                [6'd16:6'd19]: fmt_size_reg  <= {hdr_byte, fmt_size_reg[31:8]};
                [6'd20:6'd21]: format_reg    <= {hdr_byte, format_reg[15:8]};
                [6'd22:6'd23]: chan_reg      <= {hdr_byte, chan_reg[15:8]};
                [6'd24:6'd27]: rate_reg      <= {hdr_byte, rate_reg[31:8]};
                [6'd28:6'd31]: brate_reg     <= {hdr_byte, brate_reg[31:8]};
                [6'd32:6'd33]: align_reg     <= {hdr_byte, align_reg[15:8]};
                [6'd34:6'd35]: bits_reg      <= {hdr_byte, bits_reg[15:8]};
                [6'd40:6'd43]: dsize_reg     <= {hdr_byte, dsize_reg[31:8]};
                default:       ;
            endcase
        end
    end

    // two-stage product chain, settles well before the last data byte
    always_ff @(posedge clk)
    begin
        cb_prod_reg  <= {16'h0000, chan_reg} * {16'h0000, bits_reg};
        rcb_prod_reg <= 32'(rate_reg * cb_prod_reg);
    end

    // checks in file order except that the format code goes before the fmt size, first failure wins
    always_comb
    begin
        exp_brate = {3'b000, rcb_prod_reg[31:3]};
        exp_align = {3'b000, cb_prod_reg[31:3]};
        fsize_bad = (total_len_reg < whc_pkg::RIFF_OFS) ||
                    (riff_size_reg != (total_len_reg - whc_pkg::RIFF_OFS));
        dsize_bad = (total_len_reg < whc_pkg::DATA_OFS) ||
                    (dsize_reg != (total_len_reg - whc_pkg::DATA_OFS));

        if (!tag_flags_reg[whc_pkg::TAG_RIFF_BIT])
            status_next = whc_pkg::STAT_RIFF;
        else if (fsize_bad)
            status_next = whc_pkg::STAT_FSIZE;
        else if (!tag_flags_reg[whc_pkg::TAG_WAVE_BIT])
            status_next = whc_pkg::STAT_WAVE;
        else if (!tag_flags_reg[whc_pkg::TAG_FMT_BIT])
            status_next = whc_pkg::STAT_TAG;
        else if (format_reg != whc_pkg::FMT_CODE_PCM)
            status_next = whc_pkg::STAT_NOTPCM;
        else if (fmt_size_reg != whc_pkg::FMT_SIZE_PCM)
            status_next = whc_pkg::STAT_FMTSIZE;
        else if (brate_reg != exp_brate)
            status_next = whc_pkg::STAT_BRATE;
        else if ({16'h0000, align_reg} != exp_align)
            status_next = whc_pkg::STAT_ALIGN;
        else if (!tag_flags_reg[whc_pkg::TAG_DATA_BIT])
            status_next = whc_pkg::STAT_TAG;
        else if (dsize_bad)
            status_next = whc_pkg::STAT_DSIZE;
        else
            status_next = whc_pkg::STAT_OK;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg    <= status_next;
            chan_out_reg  <= chan_reg;
            rate_out_reg  <= rate_reg;
            bits_out_reg  <= bits_reg;
            dsize_out_reg <= dsize_reg;
        end
    end

    assign status        = status_reg;
    assign channel_count = chan_out_reg;
    assign rate_hz       = rate_out_reg;
    assign sample_bits   = bits_out_reg;
    assign payload_size  = dsize_out_reg;

endmodule

`default_nettype wire

[hdl/wav_header_checker.sv]
// ----------------------------------------------------------------------------
// wav_header_checker
// Checks a canonical 44-byte PCM wav header and reports the first failure.
// ----------------------------------------------------------------------------
//  channel   direction  width  contents
//  s_axis    in         8+1    header byte, tuser marks header byte 0
//  m_axis    out        104    status, channels, rate, bits, data size
//  cfg       in         32     file size, write only
//
//  One header byte per cycle is taken while parsing; the byte stream sets
//  the pace. After byte 43 the input stalls in the judge state, and stays
//  stalled while the result register is still full. The byte rate product
//  runs through two registered multipliers that settle while the data chunk
//  bytes arrive. Reset is asynchronous, active low, and leaves the block
//  idle with the file size at 44.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_header_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // header byte stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] header_byte
    input  wire logic         s_axis_tuser,   // [0] first_byte
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata,   // [3:0] status, [19:4] channel_count,
                                              // [51:20] rate_hz, [67:52] sample_bits,
                                              // [99:68] payload_size, [103:100] zero
    // configuration
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata       // total file length in bytes
);

    whc_pkg::whc_cmd_t cmd;
    logic [3:0]        status;
    logic [15:0]       channel_count;
    logic [31:0]       rate_hz;
    logic [15:0]       sample_bits;
    logic [31:0]       payload_size;

    // controller
    whc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_first (s_axis_tuser),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    // datapath
    whc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .hdr_byte      (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .status        (status),
        .channel_count (channel_count),
        .rate_hz       (rate_hz),
        .sample_bits   (sample_bits),
        .payload_size  (payload_size)
    );

    // result beat packing
    assign m_axis_tdata = {4'b0000, payload_size, sample_bits, rate_hz,
                           channel_count, status};

endmodule

`default_nettype wire

[hdl/whc_checker.sv]
// ----------------------------------------------------------------------------
// whc_checker
// Port-level checks for the wav header checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module whc_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic         s_axis_tuser,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [103:0] m_axis_tdata
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // status code within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'd9))
        else $error("status code out of range");

    // a new result follows a judge cycle with the input stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a judge cycle");

    // a header start never completes a header
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !$rose(m_axis_tvalid))
        else $error("result right after header start");

endmodule

bind wav_header_checker whc_checker u_whc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
